@@ design/mppf_pkg.sv @@
// Shared types and constants for the minute parameter frame parser.
// Used by mppf_core, mppf_out_buf and minute_parameter_frame_parser_top.
`default_nettype none

package mppf_pkg;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_BYTE    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  // Frame status as reported on the result channel
  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_PENDING = 2'd1,
    ST_DONE    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // Dense error codes
  typedef enum logic [3:0] {
    ERR_CLEAR       = 4'd0,
    ERR_BED_ORDER   = 4'd1,
    ERR_MANY_PARAMS = 4'd2,
    ERR_BAD_BUSY    = 4'd3,
    ERR_EARLY_NEXT  = 4'd4,
    ERR_MANY_MIN    = 4'd5,
    ERR_EARLY_EOT   = 4'd6,
    ERR_BAD_CTRL    = 4'd7,
    ERR_NO_ANSWER   = 4'd8,
    ERR_COMM_BREAK  = 4'd9
  } err_e;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_BED      = 2'd0,
    REG_EOT      = 2'd1,
    REG_BUSY     = 2'd2,
    REG_NEXT_MIN = 2'd3
  } reg_e;

  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [7:0] BedCodeRst     = 8'd192;
  localparam logic [7:0] EotCodeRst     = 8'd132;
  localparam logic [7:0] BusyCodeRst    = 8'd133;
  localparam logic [7:0] NextMinCodeRst = 8'd134;

  // Bit 7 set marks a control byte
  localparam int unsigned CtrlFlagBit = 7;

  typedef struct packed {
    logic [7:0] bed_code;
    logic [7:0] eot_code;
    logic [7:0] busy_code;
    logic [7:0] next_minute_code;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    err_e        error_code;
    logic        value_valid;
    logic [13:0] value;
    logic [3:0]  minute_index;
    logic [4:0]  param_index;
  } result_t;

endpackage

`default_nettype wire

@@ design/minute_parameter_frame_parser_top.sv @@
// Minute parameter frame parser: checks a serial answer frame and unpacks its values.
// Block usage:
//   Input channel (in_valid_i / in_stall_o): opcode_i start, received byte or timeout,
//   rx_byte_i the received byte. Output channel (out_valid_o / out_stall_i): exactly
//   one result per input transaction, carrying status, error code and, when a value
//   was completed, the value with its minute and parameter slot.
//   The result is registered in the output register, or in the skid register while the receiver stalls.
//   Throughput is 1 transaction per cycle while in_stall_o is low: the parse state updates in the accepting
//   cycle, so the next byte can follow at once.
//   When the receiver stalls, one more transaction lands in a skid register; after
//   that in_stall_o rises until the output drains.
//   Reset clears the frame state to idle and loads the default control codes; the
//   APB port (byte address 4*index) writes bed, eot, busy and next-minute codes and
//   should only be written while no transaction is in flight.
// Depends on mppf_pkg, mppf_core and mppf_out_buf.
`default_nettype none

module minute_parameter_frame_parser_top #(
  parameter int unsigned PARAMS_PER_MINUTE = 21,
  parameter int unsigned MINUTES           = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [1:0]                        opcode_i,
  input  wire  [7:0]                        rx_byte_i,
  // output channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [1:0]                        status_o,
  output logic [3:0]                        error_code_o,
  output logic                              value_valid_o,
  output logic [13:0]                       value_o,
  output logic [3:0]                        minute_index_o,
  output logic [4:0]                        param_index_o,
  // configuration
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [mppf_pkg::AddrWidth-1:0]    paddr,
  input  wire  [mppf_pkg::DataWidth-1:0]    pwdata,
  output logic [mppf_pkg::DataWidth-1:0]    prdata,
  output logic                              pready
);

  mppf_pkg::cfg_t    cfg_q;
  mppf_pkg::result_t res;
  mppf_pkg::result_t res_out;
  mppf_pkg::reg_e    reg_sel;
  logic              cfg_wr;
  logic              step;
  logic [7:0]        rd_byte;

  assign pready  = 1'b1;
  assign reg_sel = mppf_pkg::reg_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bed_code         <= mppf_pkg::BedCodeRst;
      cfg_q.eot_code         <= mppf_pkg::EotCodeRst;
      cfg_q.busy_code        <= mppf_pkg::BusyCodeRst;
      cfg_q.next_minute_code <= mppf_pkg::NextMinCodeRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        mppf_pkg::REG_BED:      cfg_q.bed_code         <= pwdata[7:0];
        mppf_pkg::REG_EOT:      cfg_q.eot_code         <= pwdata[7:0];
        mppf_pkg::REG_BUSY:     cfg_q.busy_code        <= pwdata[7:0];
        mppf_pkg::REG_NEXT_MIN: cfg_q.next_minute_code <= pwdata[7:0];
        default:                cfg_q                  <= cfg_q;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_sel)
      mppf_pkg::REG_BED:      rd_byte = cfg_q.bed_code;
      mppf_pkg::REG_EOT:      rd_byte = cfg_q.eot_code;
      mppf_pkg::REG_BUSY:     rd_byte = cfg_q.busy_code;
      mppf_pkg::REG_NEXT_MIN: rd_byte = cfg_q.next_minute_code;
      default:                rd_byte = '0;
    endcase
  end

  assign prdata = {{(mppf_pkg::DataWidth - 8){1'b0}}, rd_byte};

  // Advance the parser on each accepted transaction
  assign step = in_valid_i && !in_stall_o;

  mppf_core #(
    .PARAMS_PER_MINUTE (PARAMS_PER_MINUTE),
    .MINUTES           (MINUTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .opcode_i  (opcode_i),
    .rx_byte_i (rx_byte_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  mppf_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_i      (res),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (res_out)
  );

  assign status_o       = res_out.status;
  assign error_code_o   = res_out.error_code;
  assign value_valid_o  = res_out.value_valid;
  assign value_o        = res_out.value;
  assign minute_index_o = res_out.minute_index;
  assign param_index_o  = res_out.param_index;

`ifndef SYNTHESIS
  // Input stalls only while a result is held at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // Value fields are zero unless a value was completed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !value_valid_o) |->
      (value_o == '0 && minute_index_o == '0 && param_index_o == '0))
    else $error("value fields set without a completed value");

  // A completed value is only emitted while the frame is still pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && value_valid_o) |-> (status_o == mppf_pkg::ST_PENDING))
    else $error("value emitted outside a pending frame");

  // A reported error always comes with an invalid status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_code_o != mppf_pkg::ERR_CLEAR) |->
      (status_o == mppf_pkg::ST_INVALID))
    else $error("error code without invalid status");
`endif

endmodule

`default_nettype wire

@@ design/mppf_core.sv @@
// Frame parse state and the per-item check and unpack logic.
// Depends on mppf_pkg; the result is combinational, registered by mppf_out_buf.
`default_nettype none

module mppf_core #(
  parameter int unsigned PARAMS_PER_MINUTE = 21,
  parameter int unsigned MINUTES           = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   step_i,
  input  wire  [1:0]            opcode_i,
  input  wire  [7:0]            rx_byte_i,
  input  mppf_pkg::cfg_t        cfg_i,
  output mppf_pkg::result_t     res_o
);

  localparam int unsigned PW = $clog2(PARAMS_PER_MINUTE + 1);
  localparam int unsigned MW = $clog2(MINUTES + 1);

  mppf_pkg::status_e status_q, status_d;
  mppf_pkg::err_e    err_q, err_d;
  logic              bed_seen_q, bed_seen_d;
  logic              busy_seen_q, busy_seen_d;
  logic              eot_seen_q, eot_seen_d;
  logic              hh_pend_q, hh_pend_d;
  logic [6:0]        high_q, high_d;
  logic [PW-1:0]     pcnt_q, pcnt_d;
  logic [MW-1:0]     mcnt_q, mcnt_d;

  logic              is_bed;
  logic              params_full;
  logic              last_minute;
  logic              fail;
  mppf_pkg::err_e    fail_code;

  assign is_bed      = (rx_byte_i == cfg_i.bed_code);
  assign params_full = (pcnt_q == PW'(PARAMS_PER_MINUTE));
  assign last_minute = ((MW + 1)'(mcnt_q) + (MW + 1)'(1)) >= (MW + 1)'(MINUTES);

  // Work out the next parse state and the result of this item
  always_comb begin
    status_d    = status_q;
    err_d       = err_q;
    bed_seen_d  = bed_seen_q;
    busy_seen_d = busy_seen_q;
    eot_seen_d  = eot_seen_q;
    hh_pend_d   = hh_pend_q;
    high_d      = high_q;
    pcnt_d      = pcnt_q;
    mcnt_d      = mcnt_q;
    fail        = 1'b0;
    fail_code   = mppf_pkg::ERR_CLEAR;

    res_o.value_valid  = 1'b0;
    res_o.value        = '0;
    res_o.minute_index = '0;
    res_o.param_index  = '0;

    unique case (opcode_i)
      mppf_pkg::OP_START: begin
        status_d    = mppf_pkg::ST_PENDING;
        err_d       = mppf_pkg::ERR_CLEAR;
        bed_seen_d  = 1'b0;
        busy_seen_d = 1'b0;
        eot_seen_d  = 1'b0;
        hh_pend_d   = 1'b0;
        high_d      = '0;
        pcnt_d      = '0;
        mcnt_d      = '0;
      end
      mppf_pkg::OP_BYTE: begin
        if (status_q == mppf_pkg::ST_PENDING) begin
          priority if (bed_seen_q == is_bed) begin
            fail      = 1'b1;
            fail_code = mppf_pkg::ERR_BED_ORDER;
          end else if (is_bed) begin
            bed_seen_d = 1'b1;
          end else if (rx_byte_i[mppf_pkg::CtrlFlagBit]) begin
            // Control byte: checked in the order busy lock, next minute, eot, busy
            priority if (busy_seen_q && rx_byte_i != cfg_i.eot_code) begin
              fail      = 1'b1;
              fail_code = mppf_pkg::ERR_BAD_BUSY;
            end else if (rx_byte_i == cfg_i.next_minute_code) begin
              priority if (last_minute) begin
                fail      = 1'b1;
                fail_code = mppf_pkg::ERR_MANY_MIN;
              end else if (params_full) begin
                pcnt_d    = '0;
                hh_pend_d = 1'b0;
                mcnt_d    = mcnt_q + MW'(1);
              end else begin
                fail      = 1'b1;
                fail_code = mppf_pkg::ERR_EARLY_NEXT;
              end
            end else if (rx_byte_i == cfg_i.eot_code) begin
              priority if (busy_seen_q) begin
                status_d = mppf_pkg::ST_DONE;
              end else if (params_full) begin
                eot_seen_d = 1'b1;
              end else begin
                fail      = 1'b1;
                fail_code = mppf_pkg::ERR_EARLY_EOT;
              end
            end else if (rx_byte_i == cfg_i.busy_code) begin
              if (pcnt_q == '0 && mcnt_q == '0 && !hh_pend_q) begin
                busy_seen_d = 1'b1;
              end else begin
                fail      = 1'b1;
                fail_code = mppf_pkg::ERR_BAD_BUSY;
              end
            end else begin
              fail      = 1'b1;
              fail_code = mppf_pkg::ERR_BAD_CTRL;
            end
          end else if (!hh_pend_q) begin
            // High half of a value
            if (pcnt_q >= PW'(PARAMS_PER_MINUTE)) begin
              fail      = 1'b1;
              fail_code = mppf_pkg::ERR_MANY_PARAMS;
            end else begin
              high_d    = rx_byte_i[6:0];
              hh_pend_d = 1'b1;
            end
          end else begin
            // Low half completes the value
            res_o.value_valid  = 1'b1;
            res_o.value        = {1'b0, high_q, 6'b0} + {7'b0, rx_byte_i[6:0]};
            res_o.minute_index = 4'(mcnt_q);
            res_o.param_index  = 5'(pcnt_q);
            hh_pend_d          = 1'b0;
            pcnt_d             = pcnt_q + PW'(1);
          end
        end
      end
      mppf_pkg::OP_TIMEOUT: begin
        if (status_q == mppf_pkg::ST_PENDING) begin
          if (eot_seen_q) begin
            eot_seen_d = 1'b0;
            status_d   = mppf_pkg::ST_DONE;
          end else begin
            fail      = 1'b1;
            fail_code = bed_seen_q ? mppf_pkg::ERR_COMM_BREAK : mppf_pkg::ERR_NO_ANSWER;
          end
        end
      end
      default: begin
        // unused opcode: leave everything as is
      end
    endcase

    if (fail) begin
      status_d = mppf_pkg::ST_INVALID;
      err_d    = fail_code;
    end

    res_o.status     = status_d;
    res_o.error_code = err_d;
  end

  // Hold the parse state; advance it on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= mppf_pkg::ST_IDLE;
      err_q       <= mppf_pkg::ERR_CLEAR;
      bed_seen_q  <= 1'b0;
      busy_seen_q <= 1'b0;
      eot_seen_q  <= 1'b0;
      hh_pend_q   <= 1'b0;
      high_q      <= '0;
      pcnt_q      <= '0;
      mcnt_q      <= '0;
    end else if (step_i) begin
      status_q    <= status_d;
      err_q       <= err_d;
      bed_seen_q  <= bed_seen_d;
      busy_seen_q <= busy_seen_d;
      eot_seen_q  <= eot_seen_d;
      hh_pend_q   <= hh_pend_d;
      high_q      <= high_d;
      pcnt_q      <= pcnt_d;
      mcnt_q      <= mcnt_d;
    end
  end

endmodule

`default_nettype wire

@@ design/mppf_out_buf.sv @@
// Result register with a skid stage, so input and output sides are decoupled.
// Depends on mppf_pkg for the result type.
`default_nettype none

module mppf_out_buf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  mppf_pkg::result_t    data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output mppf_pkg::result_t    data_o
);

  logic              out_valid_q;
  logic              skid_valid_q;
  mppf_pkg::result_t out_q;
  mppf_pkg::result_t skid_q;
  logic              out_free;
  logic              accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;

  // Move the skid entry forward first, else take the new transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || accept;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= data_i;
      end
    end else if (accept) begin
      skid_q <= data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule

`default_nettype wire
